// ===== src/ppsr_pkg.sv =====
// Package for the PWM phase stagger router: field widths, register codes,
// payload structs and the divider pipeline geometry. Depends on nothing.
package ppsr_pkg;

	// Q format of duties and phases.
	localparam int FRAC_BITS = 16;
	localparam int DUTY_W    = FRAC_BITS + 1;
	localparam int CH_NUM    = 4;
	localparam int CH_IDX_W  = $clog2(CH_NUM);
	localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(1) << FRAC_BITS;

	// Sum of four saturated duties and the reciprocal of that sum.
	localparam int TOT_W   = DUTY_W + 2;
	localparam int RECIP_W = 2 * FRAC_BITS;

	// Divider geometry: quotient bits resolved per stage and stage count.
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (RECIP_W + 1 + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_STAGES * DIV_STEP;
	localparam int DIV_ONE_POS = DIV_W - 1 - RECIP_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int ROUTE_W    = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE3     = 3'd4;

	// Route values at or above this code leave the output disconnected.
	localparam logic [ROUTE_W-1:0] ROUTE_OFF = 3'd4;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_CENTER = 2'd1,
		MODE_STAG3  = 2'd2,
		MODE_STAG4  = 2'd3
	} phase_mode_t;

	typedef logic [DUTY_W-1:0] duty_t;
	typedef duty_t [CH_NUM-1:0] duty_vec_t;

	typedef struct packed {
		duty_t duty_red;
		duty_t duty_green;
		duty_t duty_blue;
		duty_t duty_white;
	} duty_req_t;

	typedef struct packed {
		duty_t out0_duty;
		duty_t out1_duty;
		duty_t out2_duty;
		duty_t out3_duty;
		duty_t out0_phase;
		duty_t out1_phase;
		duty_t out2_phase;
		duty_t out3_phase;
	} route_rsp_t;

	// Side data that rides through the divider with each request.
	typedef struct packed {
		duty_vec_t duty;
		logic      tot_zero;
	} ppsr_tag_t;

endpackage

// ===== src/ppsr_recip_div.sv =====
// Pipelined reciprocal unit: floor(2^(2*FRAC_BITS) / total), low RECIP_W bits,
// a few quotient bits per stage. Depends on ppsr_pkg.
module ppsr_recip_div
	import ppsr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TOT_W-1:0]   in_total,
	input  ppsr_tag_t          in_tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RECIP_W-1:0] out_recip,
	output ppsr_tag_t          out_tag
);

	// Entry 0 is the incoming request; entries 1..DIV_STAGES are registers.
	logic               v_s   [0:DIV_STAGES];
	logic [TOT_W-1:0]   rem_s [0:DIV_STAGES];
	logic [TOT_W-1:0]   tot_s [0:DIV_STAGES];
	logic [RECIP_W-1:0] quo_s [0:DIV_STAGES];
	ppsr_tag_t          tag_s [0:DIV_STAGES];
	logic               rdy   [0:DIV_STAGES];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = '0;
	assign tot_s[0] = in_total;
	assign quo_s[0] = '0;
	assign tag_s[0] = in_tag;

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready        = rdy[0];

	genvar k;
	for (k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [TOT_W-1:0]   rem_nxt;
		logic [RECIP_W-1:0] quo_nxt;

		assign rdy[k] = !v_s[k+1] || rdy[k+1];

		// Restoring division, one quotient bit per step. The dividend is a
		// single one bit, so each step shifts in a constant.
		always_comb begin : b_step
			logic [TOT_W:0]     wide;
			logic [TOT_W-1:0]   r;
			logic [RECIP_W-1:0] q;
			r = rem_s[k];
			q = quo_s[k];
			for (int j = 0; j < DIV_STEP; j++) begin
				wide = {r, 1'((k * DIV_STEP + j) == DIV_ONE_POS)};
				if (wide >= {1'b0, tot_s[k]}) begin
					wide = wide - {1'b0, tot_s[k]};
					q    = {q[RECIP_W-2:0], 1'b1};
				end else begin
					q    = {q[RECIP_W-2:0], 1'b0};
				end
				r = wide[TOT_W-1:0];
			end
			rem_nxt = r;
			quo_nxt = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_s[k]) begin
				rem_s[k+1] <= rem_nxt;
				tot_s[k+1] <= tot_s[k];
				quo_s[k+1] <= quo_nxt;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign out_recip = quo_s[DIV_STAGES];
	assign out_tag   = tag_s[DIV_STAGES];

endmodule

// ===== src/pwm_phase_stagger_router_top.sv =====
// PWM phase stagger router, top level: channel duties in, routed duties and
// start phases out. Depends on ppsr_pkg and ppsr_recip_div.

// One request enters and one result leaves per clock while the output is not
// stalled. The stages are an input register that saturates the duties and
// forms their total, DIV_STAGES stages of the reciprocal divider at DIV_STEP
// quotient bits each, a multiply stage, a phase stage and the output register.
// Every stage holds its own valid bit and stalls only when the stage after
// it is full, so the block keeps accepting requests into any bubbles while a
// finished result waits at the output. Configuration writes are always taken;
// they should be made while the pipeline is empty, because later stages read
// the registers live. Phase modes: none, centered, staggered by the
// red/green/blue total and staggered by the total of all four channels. A
// route value of four or more disconnects an output.
module pwm_phase_stagger_router_top
	import ppsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  duty_valid,
	output logic                  duty_ready,
	input  duty_req_t             duty_req,
	output logic                  route_valid,
	input  logic                  route_ready,
	output route_rsp_t            route_rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	phase_mode_t        mode_q;
	logic [ROUTE_W-1:0] route_q [CH_NUM];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			for (int i = 0; i < CH_NUM; i++) begin
				route_q[i] <= ROUTE_W'(i);
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PHASE_MODE: mode_q     <= phase_mode_t'(cfg_data[1:0]);
				CFG_ROUTE0:     route_q[0] <= cfg_data[ROUTE_W-1:0];
				CFG_ROUTE1:     route_q[1] <= cfg_data[ROUTE_W-1:0];
				CFG_ROUTE2:     route_q[2] <= cfg_data[ROUTE_W-1:0];
				CFG_ROUTE3:     route_q[3] <= cfg_data[ROUTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage handshake. Each stage loads when it is empty or when the stage
	// after it moves on.
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3, rdy4;
	logic div_in_ready, div_out_valid;

	assign rdy4       = !route_valid || route_ready;
	assign rdy3       = !v_s3 || rdy4;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || div_in_ready;
	assign duty_ready = rdy1;

	// Stage 1: saturate duties above full scale and form the total that the
	// stagger modes divide by. Mode 3 counts the white channel as well.
	duty_vec_t        d_in;
	duty_vec_t        d_sat;
	logic [TOT_W-1:0] tot_in;
	duty_vec_t        d_s1;
	logic [TOT_W-1:0] tot_s1;

	assign d_in[0] = duty_req.duty_red;
	assign d_in[1] = duty_req.duty_green;
	assign d_in[2] = duty_req.duty_blue;
	assign d_in[3] = duty_req.duty_white;

	always_comb begin
		for (int i = 0; i < CH_NUM; i++) begin
			d_sat[i] = (d_in[i] > DUTY_ONE) ? DUTY_ONE : d_in[i];
		end
		tot_in = TOT_W'(d_sat[0]) + TOT_W'(d_sat[1]) + TOT_W'(d_sat[2]);
		if (mode_q == MODE_STAG4) begin
			tot_in = tot_in + TOT_W'(d_sat[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= duty_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && duty_valid) begin
			d_s1   <= d_sat;
			tot_s1 <= tot_in;
		end
	end

	// Reciprocal of the total. A zero total gives a meaningless quotient,
	// which the phase stage ignores through the tag flag.
	ppsr_tag_t          div_in_tag, div_out_tag;
	logic [RECIP_W-1:0] recip;

	assign div_in_tag.duty     = d_s1;
	assign div_in_tag.tot_zero = (tot_s1 == '0);

	ppsr_recip_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_in_ready),
		.in_total  (tot_s1),
		.in_tag    (div_in_tag),
		.out_valid (div_out_valid),
		.out_ready (rdy2),
		.out_recip (recip),
		.out_tag   (div_out_tag)
	);

	// Stage 2: each channel's share of the period, floor(d * recip / ONE).
	// Phases wrap at full scale, so only the low FRAC_BITS of a share matter,
	// and those depend only on the low RECIP_W bits of the reciprocal.
	logic [DUTY_W+RECIP_W-1:0] prod [CH_NUM];
	logic [FRAC_BITS-1:0]      share_s2 [CH_NUM];
	duty_vec_t                 d_s2;
	logic                      tz_s2;

	always_comb begin
		for (int i = 0; i < CH_NUM; i++) begin
			prod[i] = (DUTY_W+RECIP_W)'(div_out_tag.duty[i]) * (DUTY_W+RECIP_W)'(recip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && div_out_valid) begin
			for (int i = 0; i < CH_NUM; i++) begin
				share_s2[i] <= prod[i][2*FRAC_BITS-1:FRAC_BITS];
			end
			d_s2  <= div_out_tag.duty;
			tz_s2 <= div_out_tag.tot_zero;
		end
	end

	// Stage 3: start phases. A staggered channel starts where the shares of
	// the channels before it end, wrapped to one period. A channel at zero
	// duty has a zero share, so it neither moves the others nor gets a phase.
	duty_vec_t            ph_nxt;
	logic [FRAC_BITS-1:0] acc;
	duty_vec_t            ph_s3;
	duty_vec_t            d_s3;

	always_comb begin
		acc = '0;
		for (int i = 0; i < CH_NUM; i++) begin
			ph_nxt[i] = '0;
		end
		case (mode_q) inside
			MODE_CENTER: begin
				for (int i = 0; i < CH_NUM; i++) begin
					ph_nxt[i] = (DUTY_ONE - d_s2[i]) >> 1;
				end
			end
			MODE_STAG3, MODE_STAG4: begin
				if (!tz_s2) begin
					for (int i = 0; i < CH_NUM; i++) begin
						ph_nxt[i] = (d_s2[i] != '0) ? {1'b0, acc} : '0;
						acc       = acc + share_s2[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			ph_s3 <= ph_nxt;
			d_s3  <= d_s2;
		end
	end

	// Stage 4: routing into the output register.
	duty_vec_t od_nxt, op_nxt;

	always_comb begin
		for (int k = 0; k < CH_NUM; k++) begin
			if (route_q[k] < ROUTE_OFF) begin
				od_nxt[k] = d_s3[route_q[k][CH_IDX_W-1:0]];
				op_nxt[k] = ph_s3[route_q[k][CH_IDX_W-1:0]];
			end else begin
				od_nxt[k] = '0;
				op_nxt[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_valid <= 1'b0;
		end else if (rdy4) begin
			route_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			route_rsp.out0_duty  <= od_nxt[0];
			route_rsp.out1_duty  <= od_nxt[1];
			route_rsp.out2_duty  <= od_nxt[2];
			route_rsp.out3_duty  <= od_nxt[3];
			route_rsp.out0_phase <= op_nxt[0];
			route_rsp.out1_phase <= op_nxt[1];
			route_rsp.out2_phase <= op_nxt[2];
			route_rsp.out3_phase <= op_nxt[3];
		end
	end

`ifndef SYNTHESIS
	// The input stalls only when every stage up to the output is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!duty_ready |-> v_s1 && v_s2 && v_s3 && route_valid && !route_ready)
		else $error("input stalled while the pipeline has room");

	// A disconnected output drives zero duty and zero phase.
	a_route_off: assert property (@(posedge clk) disable iff (!arst_n)
		route_valid && route_q[0] >= ROUTE_OFF |->
		route_rsp.out0_duty == '0 && route_rsp.out0_phase == '0)
		else $error("disconnected output 0 is not zero");

	// Routed duties never exceed full scale after saturation.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		route_valid |-> route_rsp.out0_duty <= DUTY_ONE &&
		route_rsp.out1_duty <= DUTY_ONE && route_rsp.out2_duty <= DUTY_ONE &&
		route_rsp.out3_duty <= DUTY_ONE)
		else $error("routed duty above full scale");

	// A staggered phase always wraps below one period.
	a_phase_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (mode_q == MODE_STAG3 || mode_q == MODE_STAG4) |->
		ph_s3[0] < DUTY_ONE && ph_s3[1] < DUTY_ONE &&
		ph_s3[2] < DUTY_ONE && ph_s3[3] < DUTY_ONE)
		else $error("staggered phase did not wrap");
`endif

endmodule

// ===== verif/ppsr_route_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the PWM phase stagger router: tracks register writes, predicts the
// routed duties and start phases of every accepted request and compares results.
// Depends on ppsr_pkg.
module ppsr_route_checker
	import ppsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  duty_valid,
	input  logic                  duty_ready,
	input  duty_req_t             duty_req,
	input  logic                  route_valid,
	input  logic                  route_ready,
	input  route_rsp_t            route_rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    routed
);

	phase_mode_t        mode_q;
	logic [ROUTE_W-1:0] route_q [CH_NUM];
	route_rsp_t         expected_routes [$];

	// Saturate the duties, derive each channel's start phase for the current mode,
	// then route duty and phase pairs to the four outputs.
	function automatic route_rsp_t predict_route(duty_req_t req);
		longint unsigned full;
		longint unsigned duty [CH_NUM];
		longint unsigned start [CH_NUM];
		longint unsigned total;
		longint unsigned recip;
		longint unsigned run;
		duty_t [0:7]     fields;
		int              ch;
		full = 64'd1 << FRAC_BITS;
		duty[0] = req.duty_red;
		duty[1] = req.duty_green;
		duty[2] = req.duty_blue;
		duty[3] = req.duty_white;
		for (ch = 0; ch < CH_NUM; ch++) begin
			if (duty[ch] > full)
				duty[ch] = full;
			start[ch] = 0;
		end
		case (mode_q) inside
			MODE_CENTER: begin
				for (ch = 0; ch < CH_NUM; ch++)
					start[ch] = (full - duty[ch]) >> 1;
			end
			MODE_STAG3, MODE_STAG4: begin
				total = duty[0] + duty[1] + duty[2];
				if (mode_q == MODE_STAG4)
					total += duty[3];
				// The white channel is still staggered in the three-channel mode,
				// it just does not count toward the total.
				if (total != 0) begin
					recip = (64'd1 << (2 * FRAC_BITS)) / total;
					run = 0;
					for (ch = 0; ch < CH_NUM; ch++) begin
						if (duty[ch] != 0) begin
							run &= full - 1;
							start[ch] = run;
							run += (duty[ch] * recip) >> FRAC_BITS;
						end
					end
				end
			end
			default: ;
		endcase
		for (ch = 0; ch < CH_NUM; ch++) begin
			if (route_q[ch] < ROUTE_OFF) begin
				fields[ch]          = duty_t'(duty[route_q[ch]]);
				fields[CH_NUM + ch] = duty_t'(start[route_q[ch]]);
			end else begin
				fields[ch]          = '0;
				fields[CH_NUM + ch] = '0;
			end
		end
		return route_rsp_t'(fields);
	endfunction

	task automatic compare_route(route_rsp_t got);
		route_rsp_t  want;
		duty_t [0:7] w;
		duty_t [0:7] g;
		int          i;
		if (expected_routes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %h arrived with no request outstanding", $time, got);
			return;
		end
		want = expected_routes.pop_front();
		w = want;
		g = got;
		for (i = 0; i < 8; i++) begin
			if (w[i] !== g[i]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d, %s expected %0d, got %0d", $time, routed,
						(i < CH_NUM) ? $sformatf("out%0d_duty", i)
							: $sformatf("out%0d_phase", i - CH_NUM),
						w[i], g[i]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_NONE;
			route_q[0] = 3'd0;
			route_q[1] = 3'd1;
			route_q[2] = 3'd2;
			route_q[3] = 3'd3;
			expected_routes.delete();
			mismatches = 0;
			routed = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PHASE_MODE: mode_q = phase_mode_t'(cfg_data[1:0]);
					CFG_ROUTE0: route_q[0] = cfg_data[ROUTE_W-1:0];
					CFG_ROUTE1: route_q[1] = cfg_data[ROUTE_W-1:0];
					CFG_ROUTE2: route_q[2] = cfg_data[ROUTE_W-1:0];
					CFG_ROUTE3: route_q[3] = cfg_data[ROUTE_W-1:0];
					default: ;
				endcase
			end
			if (duty_valid && duty_ready)
				expected_routes.insert(expected_routes.size(), predict_route(duty_req));
			if (route_valid && route_ready) begin
				compare_route(route_rsp);
				routed++;
			end
			pending = expected_routes.size();
		end
	end

endmodule

// ===== verif/pwm_phase_stagger_router_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the PWM phase stagger router: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on ppsr_pkg, the block
// and ppsr_route_checker.
module pwm_phase_stagger_router_top_test;
	import ppsr_pkg::*;

	// Random phases, each with its own register setting, and their request count.
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 152;
	// The phase in which the result side holds off long enough to back up the pipe.
	localparam int PRESSURE_PHASE  = 5;
	localparam int HOLD_CYCLES     = 300;
	// Allow a margin after the last result.
	localparam int DRAIN_CYCLES    = DIV_STAGES + 12;
	localparam int CYCLE_LIMIT     = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  duty_valid;
	logic                  duty_ready;
	duty_req_t             duty_req;
	logic                  route_valid;
	logic                  route_ready;
	route_rsp_t            route_rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   mismatches;
	int   pending;
	int   routed;
	int   cycles;
	int   settings;
	logic idle_on;
	logic hold_req;

	pwm_phase_stagger_router_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.duty_valid  (duty_valid),
		.duty_ready  (duty_ready),
		.duty_req    (duty_req),
		.route_valid (route_valid),
		.route_ready (route_ready),
		.route_rsp   (route_rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	ppsr_route_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.duty_valid  (duty_valid),
		.duty_ready  (duty_ready),
		.duty_req    (duty_req),
		.route_valid (route_valid),
		.route_ready (route_ready),
		.route_rsp   (route_rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pending     (pending),
		.routed      (routed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// One register write. All inputs move on the falling edge, so the block and the
	// checker both see a settled index and data at the rising edge that takes it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers are only written with the pipeline empty, since later stages read them
	// live. Every request makes exactly one result, so an empty expected store means
	// nothing is left in flight. The unused upper data bits are filled with noise to
	// show they are dropped, and now and then an index past the last route register is
	// written, which the block must ignore.
	task automatic apply_setting(input phase_mode_t mode, input logic [ROUTE_W-1:0] r0,
		input logic [ROUTE_W-1:0] r1, input logic [ROUTE_W-1:0] r2,
		input logic [ROUTE_W-1:0] r3);
		logic [CFG_DATA_W-1:0] v;
		duty_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		v = CFG_DATA_W'($urandom);
		v[1:0] = mode;
		write_reg(CFG_PHASE_MODE, v);
		v = CFG_DATA_W'($urandom);
		v[ROUTE_W-1:0] = r0;
		write_reg(CFG_ROUTE0, v);
		v = CFG_DATA_W'($urandom);
		v[ROUTE_W-1:0] = r1;
		write_reg(CFG_ROUTE1, v);
		v = CFG_DATA_W'($urandom);
		v[ROUTE_W-1:0] = r2;
		write_reg(CFG_ROUTE2, v);
		v = CFG_DATA_W'($urandom);
		v[ROUTE_W-1:0] = r3;
		write_reg(CFG_ROUTE3, v);
		if ($urandom_range(0, 1) == 0)
			write_reg(CFG_ROUTE3 + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
		settings++;
	endtask

	// Offer one request and hold it until the block takes it. Valid stays high into the
	// next request unless a random idle burst comes first.
	task automatic send_request(input duty_req_t req);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			duty_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		duty_req   = req;
		duty_valid = 1'b1;
		do @(posedge clk); while (!duty_ready);
		@(negedge clk);
	endtask

	task automatic send_duties(input int r, input int g, input int b, input int w);
		duty_req_t req;
		req.duty_red   = duty_t'(r);
		req.duty_green = duty_t'(g);
		req.duty_blue  = duty_t'(b);
		req.duty_white = duty_t'(w);
		send_request(req);
	endtask

	// Directed corners: all dark, all full on, duties above full scale that must
	// saturate, white alone (zero total in the three-channel stagger, a total of one
	// in the four-channel one), tiny duties with a huge reciprocal, and gaps.
	task automatic send_directed();
		send_duties(0, 0, 0, 0);
		send_duties(DUTY_ONE, DUTY_ONE, DUTY_ONE, DUTY_ONE);
		send_duties(2 ** DUTY_W - 1, DUTY_ONE + 1, DUTY_ONE - 1, 1);
		send_duties(0, 0, 0, 1);
		send_duties(1, 2, 3, 4);
		send_duties(DUTY_ONE, 0, 2 ** DUTY_W - 1, 0);
	endtask

	// Duties weighted toward zero, full scale and small values, where the stagger
	// arithmetic has its edges; some duties land above full scale to exercise saturation.
	function automatic duty_t random_duty();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return '0;
		if (pick < 30)
			return DUTY_ONE;
		if (pick < 36)
			return duty_t'($urandom_range(int'(DUTY_ONE) + 1, 2 ** DUTY_W - 1));
		if (pick < 46)
			return duty_t'($urandom_range(1, 255));
		return duty_t'($urandom_range(0, int'(DUTY_ONE) - 1));
	endfunction

	function automatic logic [ROUTE_W-1:0] random_route();
		if ($urandom_range(0, 3) == 0)
			return ROUTE_W'($urandom_range(int'(ROUTE_OFF), 2 ** ROUTE_W - 1));
		return ROUTE_W'($urandom_range(0, CH_NUM - 1));
	endfunction

	// Result side: random stall bursts while idling is on, and one long hold-off when
	// the stimulus asks for it. The hold-off is counted here so that the sender keeps
	// offering requests and the block has to fill up and drop its input ready.
	initial begin
		int held;
		route_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				route_ready = 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_req    = 1'b0;
				route_ready = 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				route_ready = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				route_ready = 1'b1;
			end
		end
	end

	initial begin
		int                 p;
		int                 n;
		duty_req_t          req;
		phase_mode_t        mode;
		logic [ROUTE_W-1:0] rt [CH_NUM];
		arst_n     = 1'b0;
		duty_valid = 1'b0;
		duty_req   = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_PHASE_MODE;
		cfg_data   = '0;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		settings   = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first directed pass runs on the reset values: no phases, straight routes.
		send_directed();
		apply_setting(MODE_CENTER, 3'd0, 3'd1, 3'd2, 3'd3);
		send_directed();
		apply_setting(MODE_STAG3, 3'd0, 3'd1, 3'd2, 3'd3);
		send_directed();
		apply_setting(MODE_STAG4, 3'd3, 3'd2, 3'd1, 3'd0);
		send_directed();

		// Random phases walk through every mode several times. The first few use
		// extreme routings: every disconnect code, all outputs on red, all outputs on
		// white and all on the highest code. The last two run without any idling.
		for (p = 0; p < PHASES; p++) begin
			mode = phase_mode_t'(p % 4);
			case (p)
				0: begin
					rt[0] = 3'd4;
					rt[1] = 3'd5;
					rt[2] = 3'd6;
					rt[3] = 3'd7;
				end
				1: begin
					for (n = 0; n < CH_NUM; n++)
						rt[n] = 3'd0;
				end
				2: begin
					for (n = 0; n < CH_NUM; n++)
						rt[n] = 3'd3;
				end
				3: begin
					for (n = 0; n < CH_NUM; n++)
						rt[n] = 3'd7;
				end
				default: begin
					for (n = 0; n < CH_NUM; n++)
						rt[n] = random_route();
				end
			endcase
			idle_on = (p < PHASES - 2) && (p % 3 != 2);
			apply_setting(mode, rt[0], rt[1], rt[2], rt[3]);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == PRESSURE_PHASE && n == 20)
					hold_req = 1'b1;
				req.duty_red   = random_duty();
				req.duty_green = random_duty();
				req.duty_blue  = random_duty();
				req.duty_white = random_duty();
				send_request(req);
			end
		end
		duty_valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d routed results over %0d register settings in %0d cycles,",
			routed, settings, cycles);
		$display("covering all phase modes, saturated duties, zero totals and disconnected outputs.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
